/* design/qmim_pkg.sv */
// shared types and constants for the implicant merge round block
package qmim_pkg;

    localparam int VAL_W       = 8;
    localparam int GRP_W       = 4;
    localparam int CFG_W       = 4;
    localparam int IDX_W       = 3;
    localparam int MAX_VARS    = 8;
    localparam int MAX_TERMS   = 8;
    localparam int MAX_RESULTS = 64;

    localparam logic KIND_MERGE = 1'b0;
    localparam logic KIND_PRIME = 1'b1;

    typedef struct packed {
        logic [VAL_W-1:0] in_value;
        logic [VAL_W-1:0] in_dash;
        logic [GRP_W-1:0] in_group;
        logic             in_last;
    } t_in_item;

    typedef struct packed {
        logic             out_kind;
        logic [VAL_W-1:0] out_value;
        logic [VAL_W-1:0] out_dash;
        logic [GRP_W-1:0] out_group;
        logic [IDX_W-1:0] out_index;
        logic             out_prime;
        logic             out_overflow;
        logic             out_last;
    } t_out_item;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] dash;
        logic [GRP_W-1:0] group;
    } t_term;

endpackage

/* design/qm_implicant_merge_round_top.sv */
// one quine-mccluskey combining round over a small term store
//
// usage: terms arrive on the input channel (valid/ready), one item per cycle,
// and are stored in load order; an item with in_last set also loads its term
// and starts the round. o_in_ready is low from then until the round's last
// result has been placed in the output register.
// the round compares every stored pair (a, b) once for each group i below
// num_vars (capped at 8) through one shared compare unit fed by a two-port
// term memory, one pair per cycle while the output register is not stalled,
// then emits one prime-status item per stored term. merged items come first,
// in group, then load order; the prime-status items follow in load order and
// the final one carries out_last.
// the user must write num_vars (i_cfg_we/i_cfg_data) only while the block is idle;
// the block does not enforce this. results sit in one output register; while a
// result waits and the receiver holds i_out_ready low, the sequencer stalls and nothing is lost.
// reset empties the store, sets every prime flag, sets num_vars to 8 and
// drops any pending output item.
module qm_implicant_merge_round_top
    import qmim_pkg::*;
#(
    parameter int P_MAX_TERMS = MAX_TERMS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    localparam int IW        = (P_MAX_TERMS > 1) ? $clog2(P_MAX_TERMS) : 1;
    localparam int CW        = $clog2(P_MAX_TERMS + 1);
    localparam int MERGE_CAP = MAX_RESULTS - P_MAX_TERMS;
    localparam int MCW       = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_PRIME
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_num_vars;
    logic [CW-1:0]          r_count;
    logic [MCW-1:0]         r_merge_cnt;
    logic                   r_ovf;
    logic [P_MAX_TERMS-1:0] r_prime;
    logic [GRP_W-1:0]       r_i;
    logic [IW-1:0]          r_a;
    logic [IW-1:0]          r_b;
    logic [IW-1:0]          r_p;
    logic                   r_s_valid;
    logic [GRP_W-1:0]       r_s_i;
    logic [IW-1:0]          r_s_a;
    logic [IW-1:0]          r_s_b;
    t_term                  r_rd_a;
    t_term                  r_rd_b;
    t_term                  r_mem [P_MAX_TERMS];
    logic                   r_out_valid;
    t_out_item              r_out;

    logic             w_adv;
    logic             w_in_acc;
    logic [GRP_W-1:0] w_nv;
    logic [VAL_W:0]   w_mask_full;
    logic [VAL_W-1:0] w_mask;
    logic [VAL_W-1:0] w_da;
    logic [VAL_W-1:0] w_db;
    logic [VAL_W-1:0] w_diff;
    logic [VAL_W-1:0] w_nd;
    logic             w_hit;
    logic [CW-1:0]    w_last_idx;
    t_out_item        w_merge_item;
    t_out_item        w_prime_item;

    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign w_last_idx  = CW'(r_count - CW'(1));

    always_comb begin
        w_nv = (r_num_vars > GRP_W'(MAX_VARS)) ? GRP_W'(MAX_VARS) : r_num_vars;
        w_mask_full = (VAL_W+1)'((VAL_W+1)'(1) << w_nv) - (VAL_W+1)'(1);
        w_mask = w_mask_full[VAL_W-1:0];
        w_da   = r_rd_a.dash & w_mask;
        w_db   = r_rd_b.dash & w_mask;
        // differs where the dash state differs or both literals disagree
        w_diff = ((w_da ^ w_db) | (~(w_da | w_db) & (r_rd_a.value ^ r_rd_b.value))) & w_mask;
        w_nd   = (w_da | w_diff) & w_mask;
        w_hit  = r_s_valid
              && (r_rd_a.group == r_s_i)
              && (r_rd_b.group == GRP_W'(r_s_i + GRP_W'(1)))
              && ($countones(w_diff) == 1);

        w_merge_item              = '0;
        w_merge_item.out_kind     = KIND_MERGE;
        w_merge_item.out_value    = r_rd_a.value & ~w_nd & w_mask;
        w_merge_item.out_dash     = w_nd;
        w_merge_item.out_group    = r_s_i;

        w_prime_item              = '0;
        w_prime_item.out_kind     = KIND_PRIME;
        w_prime_item.out_index    = IDX_W'(r_p);
        w_prime_item.out_prime    = r_prime[r_p];
        w_prime_item.out_overflow = r_ovf;
        w_prime_item.out_last     = (CW'(r_p) == w_last_idx);
    end

    // term store, one write port and two registered read ports
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (r_count < CW'(P_MAX_TERMS))) begin
            r_mem[r_count[IW-1:0]] <= '{value: i_in_item.in_value,
                                        dash:  i_in_item.in_dash,
                                        group: i_in_item.in_group};
        end
        if ((r_state == ST_SCAN) && w_adv) begin
            r_rd_a <= r_mem[r_a];
            r_rd_b <= r_mem[r_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_num_vars  <= CFG_W'(MAX_VARS);
            r_count     <= '0;
            r_merge_cnt <= '0;
            r_ovf       <= 1'b0;
            r_prime     <= '1;
            r_i         <= '0;
            r_a         <= '0;
            r_b         <= '0;
            r_p         <= '0;
            r_s_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_num_vars <= i_cfg_data;
            end
            if (w_adv) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        if (r_count < CW'(P_MAX_TERMS)) begin
                            r_prime[r_count[IW-1:0]] <= 1'b1;
                            r_count                  <= CW'(r_count + CW'(1));
                        end
                        if (i_in_item.in_last) begin
                            r_i         <= '0;
                            r_a         <= '0;
                            r_b         <= '0;
                            r_p         <= '0;
                            r_merge_cnt <= '0;
                            r_ovf       <= 1'b0;
                            r_state     <= (w_nv == '0) ? ST_PRIME : ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (w_adv) begin
                        r_s_valid <= 1'b1;
                        r_s_i     <= r_i;
                        r_s_a     <= r_a;
                        r_s_b     <= r_b;
                        if (CW'(r_b) == w_last_idx) begin
                            r_b <= '0;
                            if (CW'(r_a) == w_last_idx) begin
                                r_a <= '0;
                                if (r_i == GRP_W'(w_nv - GRP_W'(1))) begin
                                    r_state <= ST_DRAIN;
                                end else begin
                                    r_i <= GRP_W'(r_i + GRP_W'(1));
                                end
                            end else begin
                                r_a <= IW'(r_a + IW'(1));
                            end
                        end else begin
                            r_b <= IW'(r_b + IW'(1));
                        end
                    end
                end
                ST_DRAIN: begin
                    if (w_adv) begin
                        r_s_valid <= 1'b0;
                        r_p       <= '0;
                        r_state   <= ST_PRIME;
                    end
                end
                ST_PRIME: begin
                    if (w_adv) begin
                        r_out_valid <= 1'b1;
                        r_out       <= w_prime_item;
                        if (CW'(r_p) == w_last_idx) begin
                            r_count     <= '0;
                            r_merge_cnt <= '0;
                            r_state     <= ST_IDLE;
                        end else begin
                            r_p <= IW'(r_p + IW'(1));
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // compare stage: the pair read at the previous scan step
            if (w_adv && w_hit) begin
                r_prime[r_s_a] <= 1'b0;
                r_prime[r_s_b] <= 1'b0;
                if (r_merge_cnt < MCW'(MERGE_CAP)) begin
                    r_out_valid <= 1'b1;
                    r_out       <= w_merge_item;
                    r_merge_cnt <= MCW'(r_merge_cnt + MCW'(1));
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

endmodule

/* verif/tb_qm_implicant_merge_round_top.sv */
// self-checking testbench for the implicant merge round block, with its own round predictor
module tb_qm_implicant_merge_round_top
    import qmim_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT     = 5000;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_AFTER  = 100;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int unsigned DRAIN_CYCLES    = 20;
    localparam int unsigned IDLE_PERCENT    = 36;
    localparam int unsigned PHASE_TERMS     = 40;
    localparam int unsigned MERGE_CAP       = MAX_RESULTS - MAX_TERMS;
    localparam int unsigned MAX_PRINTED     = 40;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_we    = 1'b0;
    logic [CFG_W-1:0] i_cfg_data  = '0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_ready;
    t_in_item         i_in_item   = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    t_out_item        o_out_item;

    t_term            term_store [MAX_TERMS];
    bit               prime_flag [MAX_TERMS];
    int unsigned      stored_terms = 0;
    logic [CFG_W-1:0] num_vars_cfg = 4'd8;

    t_out_item   expected_results [$];
    t_in_item    pending_terms [$];
    int unsigned terms_offered = 0;
    int unsigned terms_taken   = 0;
    int unsigned n_errors      = 0;
    int unsigned stall_cycles  = 0;
    int unsigned cycle_count   = 0;
    bit          in_taken      = 1'b0;
    bit          hold_off      = 1'b0;

    qm_implicant_merge_round_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic report_mismatch(string msg);
        if (n_errors < MAX_PRINTED) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        n_errors++;
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %h want %h", name, got, want));
        end
    endtask

    function automatic logic [VAL_W-1:0] var_mask();
        int unsigned nv;
        nv = (num_vars_cfg > MAX_VARS) ? MAX_VARS : num_vars_cfg;
        return VAL_W'((1 << nv) - 1);
    endfunction

    // store one term; a last term runs the whole round and queues its results
    function automatic void load_term_and_predict(t_in_item it);
        int unsigned nv, g, a, b, merges;
        logic [VAL_W-1:0] mask, da, db, diff, nd;
        bit dropped;
        t_out_item r;
        if (stored_terms < MAX_TERMS) begin
            term_store[stored_terms] = '{value: it.in_value, dash: it.in_dash,
                                         group: it.in_group};
            prime_flag[stored_terms] = 1'b1;
            stored_terms++;
        end
        if (!it.in_last) begin
            return;
        end
        nv = (num_vars_cfg > MAX_VARS) ? MAX_VARS : num_vars_cfg;
        mask = var_mask();
        merges = 0;
        dropped = 1'b0;
        for (g = 0; g < nv; g++) begin
            for (a = 0; a < stored_terms; a++) begin
                if (term_store[a].group != g) continue;
                for (b = 0; b < stored_terms; b++) begin
                    if (term_store[b].group != g + 1) continue;
                    da = term_store[a].dash & mask;
                    db = term_store[b].dash & mask;
                    diff = ((da ^ db) | (~(da | db) &
                           (term_store[a].value ^ term_store[b].value))) & mask;
                    if ($countones(diff) != 1) continue;
                    if (merges < MERGE_CAP) begin
                        nd = (da | diff) & mask;
                        r = '0;
                        r.out_kind  = KIND_MERGE;
                        r.out_value = term_store[a].value & ~nd & mask;
                        r.out_dash  = nd;
                        r.out_group = GRP_W'(g);
                        expected_results.push_back(r);
                        merges++;
                    end else begin
                        dropped = 1'b1;
                    end
                    prime_flag[a] = 1'b0;
                    prime_flag[b] = 1'b0;
                end
            end
        end
        for (a = 0; a < stored_terms; a++) begin
            r = '0;
            r.out_kind     = KIND_PRIME;
            r.out_index    = IDX_W'(a);
            r.out_prime    = prime_flag[a];
            r.out_overflow = dropped;
            r.out_last     = (a + 1 == stored_terms);
            expected_results.push_back(r);
        end
        stored_terms = 0;
    endfunction

    function automatic t_in_item make_term(logic [VAL_W-1:0] v, logic [VAL_W-1:0] d,
                                           logic [GRP_W-1:0] g, bit last);
        t_in_item it;
        it.in_value = v;
        it.in_dash  = d;
        it.in_group = g;
        it.in_last  = last;
        return it;
    endfunction

    function automatic void offer(t_in_item it);
        pending_terms.push_back(it);
        terms_offered++;
    endfunction

    // mostly neighbours of one base term so that many pairs merge
    function automatic void queue_term_list(int unsigned n);
        int unsigned j, k;
        logic [VAL_W-1:0] mask, base_val, base_dash, v, d;
        logic [GRP_W-1:0] grp;
        mask = var_mask();
        base_val = VAL_W'($urandom);
        base_dash = VAL_W'($urandom & $urandom & $urandom);
        for (j = 0; j < n; j++) begin
            v = base_val;
            d = base_dash;
            k = $urandom_range(VAL_W - 1);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: v = v ^ VAL_W'(1 << k);
                6: d = d | VAL_W'(1 << k);
                7: ;
                8: begin
                    v = VAL_W'($urandom);
                    d = VAL_W'($urandom);
                end
                default: v = v ^ VAL_W'(1 << k) ^ VAL_W'(1 << $urandom_range(VAL_W - 1));
            endcase
            grp = GRP_W'($countones(v & ~d & mask));
            if ($urandom_range(11) == 0) begin
                grp = GRP_W'($urandom);
            end
            offer(make_term(v, d, grp, j == n - 1));
        end
    endfunction

    function automatic bit take_break();
        bit quiet;
        quiet = (cycle_count % 3000) >= 2000 && (cycle_count % 3000) < 2800;
        return !quiet && $urandom_range(99) < IDLE_PERCENT;
    endfunction

    task automatic write_num_vars(logic [CFG_W-1:0] v);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        num_vars_cfg = v;
    endtask

    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (terms_taken != terms_offered || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive_terms
        t_in_item nxt_item;
        logic     nxt_valid;
        nxt_valid = i_in_valid;
        nxt_item  = i_in_item;
        if (!i_rst_n) begin
            nxt_valid = 1'b0;
        end else if (!i_in_valid || in_taken) begin
            nxt_valid = 1'b0;
            if (pending_terms.size() != 0 && !take_break()) begin
                nxt_item  = pending_terms.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_item  <= nxt_item;
    end

    always @(negedge i_clk) begin
        i_out_ready <= i_rst_n && !hold_off && !take_break();
    end

    always @(posedge i_clk) begin : watch_results
        t_out_item want;
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                in_taken = 1'b1;
                terms_taken++;
                load_term_and_predict(i_in_item);
            end
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result item %h with none expected",
                                              o_out_item));
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_kind", 8'(o_out_item.out_kind), 8'(want.out_kind));
                    check_field("out_value", o_out_item.out_value, want.out_value);
                    check_field("out_dash", o_out_item.out_dash, want.out_dash);
                    check_field("out_group", 8'(o_out_item.out_group),
                                8'(want.out_group));
                    check_field("out_index", 8'(o_out_item.out_index),
                                8'(want.out_index));
                    check_field("out_prime", 8'(o_out_item.out_prime),
                                8'(want.out_prime));
                    check_field("out_overflow", 8'(o_out_item.out_overflow),
                                8'(want.out_overflow));
                    check_field("out_last", 8'(o_out_item.out_last), 8'(want.out_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // long receiver stall while terms keep coming, so the input backs up
    initial begin : receiver_hold_off
        do @(negedge i_clk);
        while (terms_taken < HOLD_OFF_AFTER);
        hold_off = 1'b1;
        repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
        hold_off = 1'b0;
    end

    initial begin : stimulus
        logic [CFG_W-1:0] phase_nv [8];
        int unsigned j, p, start;
        logic [VAL_W-1:0] v;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // adjacent groups forming a square of merges
        offer(make_term(8'h00, 8'h00, 4'd0, 1'b0));
        offer(make_term(8'h01, 8'h00, 4'd1, 1'b0));
        offer(make_term(8'h03, 8'h00, 4'd2, 1'b0));
        offer(make_term(8'h02, 8'h00, 4'd1, 1'b1));
        // dashed terms, with a literal bit under the dash and a dash mismatch
        offer(make_term(8'h00, 8'h01, 4'd0, 1'b0));
        offer(make_term(8'h03, 8'h01, 4'd1, 1'b0));
        offer(make_term(8'h04, 8'h02, 4'd1, 1'b1));
        // field extremes
        offer(make_term(8'h7F, 8'h00, 4'd7, 1'b0));
        offer(make_term(8'hFF, 8'h00, 4'd8, 1'b0));
        offer(make_term(8'hFF, 8'hFF, 4'd0, 1'b0));
        offer(make_term(8'h00, 8'hFF, 4'd0, 1'b1));
        // overfull store: the last two terms are dropped, the last still starts
        for (j = 0; j < MAX_TERMS + 2; j++) begin
            v = VAL_W'(j * 37);
            offer(make_term(v, 8'h00, GRP_W'($countones(v)), j == MAX_TERMS + 1));
        end
        // lone last term with an out-of-range group
        offer(make_term(8'hFF, 8'hFF, 4'd15, 1'b1));
        wait_until_drained();

        phase_nv = '{4'd0, 4'd1, 4'd15, 4'd8, 4'd2, 4'd5, 4'd6, 4'd9};
        phase_nv[5] = CFG_W'($urandom_range(1, MAX_VARS));
        for (p = 0; p < 8; p++) begin
            write_num_vars(phase_nv[p]);
            start = terms_offered;
            while (terms_offered - start < PHASE_TERMS) begin
                if ($urandom_range(9) == 0) begin
                    queue_term_list($urandom_range(MAX_TERMS + 1, MAX_TERMS + 3));
                end else begin
                    queue_term_list($urandom_range(1, MAX_TERMS));
                end
            end
            wait_until_drained();
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d result items never arrived",
                                      expected_results.size()));
        end
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/qmim_pkg.sv
design/qm_implicant_merge_round_top.sv
verif/tb_qm_implicant_merge_round_top.sv
